// ===== design/pcrc_pkg.sv =====
// Package for the parameterized CRC engine: widths, reset values of the
// configuration registers, register and operation codes, control struct.
// No dependencies.
package pcrc_pkg;

  // Fixed field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CRC_OUT_W  = 64;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned REG_SLOT_LSB = 3;   // 8-byte register slots
  localparam int unsigned WIDTH_REG_W  = 7;

  // Default largest CRC width
  localparam int unsigned DEF_MAX_WIDTH = 64;

  // Smallest supported CRC width
  localparam logic [WIDTH_REG_W-1:0] CRC_W_MIN = 7'd3;

  // Reset values (CRC-32, reflected)
  localparam logic [WIDTH_REG_W-1:0] RST_CRC_WIDTH = 7'd32;
  localparam logic [CFG_DATA_W-1:0]  RST_POLY      = 64'h0000_0000_04C1_1DB7;
  localparam logic [CFG_DATA_W-1:0]  RST_SEED      = 64'h0000_0000_FFFF_FFFF;
  localparam logic [CFG_DATA_W-1:0]  RST_XOR       = 64'h0000_0000_FFFF_FFFF;
  localparam logic                   RST_REF_IN    = 1'b1;
  localparam logic                   RST_REF_OUT   = 1'b1;

  // Register index codes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_CRC_WIDTH  = 3'd0,
    REG_POLYNOMIAL = 3'd1,
    REG_SEED       = 3'd2,
    REG_FINAL_XOR  = 3'd3,
    REG_REFLECT_IN = 3'd4,
    REG_REFLECT_OUT = 3'd5
  } reg_idx_e;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ABSORB        = 2'd0,
    OP_ABSORB_FINISH = 2'd1,
    OP_FINISH        = 2'd2
  } op_e;

  // Control from the register block to the datapath
  typedef struct packed {
    logic ref_in;   // byte taken LSB first, register kept reflected
    logic ref_out;  // result reported reflected
    logic hold;     // configuration just changed, derived values settling
    logic reload;   // load the CRC register from the seed
  } ctrl_t;

endpackage

// ===== design/pcrc_in_if.sv =====
// Input channel of the CRC engine: valid/ready plus operation and data byte.
// Depends on pcrc_pkg.
interface pcrc_in_if import pcrc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

// ===== design/pcrc_out_if.sv =====
// Result channel of the CRC engine: valid/ready plus the finished CRC.
// Depends on pcrc_pkg.
interface pcrc_out_if import pcrc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CRC_OUT_W-1:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

// ===== design/pcrc_cfg_regs.sv =====
// APB register block of the CRC engine. Holds the six configuration registers
// and registers the values the datapath derives from them. Depends on pcrc_pkg.
module pcrc_cfg_regs import pcrc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int unsigned SW = $clog2(MAX_WIDTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output ctrl_t                 ctrl_o,
  output logic [MAX_WIDTH-1:0]  poly_o,
  output logic [MAX_WIDTH-1:0]  seed_o,
  output logic [MAX_WIDTH-1:0]  xmask_o,
  output logic [SW-1:0]         shamt_o
);

  localparam logic [WIDTH_REG_W-1:0] WMAX = WIDTH_REG_W'(MAX_WIDTH);

  logic [WIDTH_REG_W-1:0] width_q;
  logic [CFG_DATA_W-1:0]  poly_q, seed_q, xor_q;
  logic                   rin_q, rout_q;
  logic                   rl1_q, rl1_d, rl2_q;
  logic                   wr_en;
  reg_idx_e               idx;

  logic [WIDTH_REG_W-1:0] w_eff, s_full;
  logic [SW-1:0]          shamt_d, shamt_q;
  logic [MAX_WIDTH-1:0]   mask, pm, sm, pm_rev, sm_rev;
  logic [MAX_WIDTH-1:0]   poly_d, seed_d, xmask_d;
  logic [MAX_WIDTH-1:0]   poly_q2, seed_q2, xmask_q;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[CFG_ADDR_W-1:REG_SLOT_LSB]);

  // Register writes; a write to a known register reloads the CRC
  always_comb begin
    rl1_d = 1'b0;
    if (wr_en) begin
      unique case (idx)
        REG_CRC_WIDTH, REG_POLYNOMIAL, REG_SEED,
        REG_FINAL_XOR, REG_REFLECT_IN, REG_REFLECT_OUT: rl1_d = 1'b1;
        default: rl1_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= RST_CRC_WIDTH;
      poly_q  <= RST_POLY;
      seed_q  <= RST_SEED;
      xor_q   <= RST_XOR;
      rin_q   <= RST_REF_IN;
      rout_q  <= RST_REF_OUT;
    end else if (wr_en) begin
      unique case (idx)
        REG_CRC_WIDTH:   width_q <= pwdata[WIDTH_REG_W-1:0];
        REG_POLYNOMIAL:  poly_q  <= pwdata;
        REG_SEED:        seed_q  <= pwdata;
        REG_FINAL_XOR:   xor_q   <= pwdata;
        REG_REFLECT_IN:  rin_q   <= pwdata[0];
        REG_REFLECT_OUT: rout_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Readback
  always_comb begin
    unique case (idx)
      REG_CRC_WIDTH:   prdata = CFG_DATA_W'(width_q);
      REG_POLYNOMIAL:  prdata = poly_q;
      REG_SEED:        prdata = seed_q;
      REG_FINAL_XOR:   prdata = xor_q;
      REG_REFLECT_IN:  prdata = CFG_DATA_W'(rin_q);
      REG_REFLECT_OUT: prdata = CFG_DATA_W'(rout_q);
      default:         prdata = '0;
    endcase
  end

  // Effective width and distance from the top of the register
  always_comb begin
    if (width_q < CRC_W_MIN) begin
      w_eff = CRC_W_MIN;
    end else if (width_q > WMAX) begin
      w_eff = WMAX;
    end else begin
      w_eff = width_q;
    end
    s_full  = WMAX - w_eff;
    shamt_d = s_full[SW-1:0];
  end

  // Masked values and their reversal over the full register
  assign mask = {MAX_WIDTH{1'b1}} >> shamt_d;
  assign pm   = poly_q[MAX_WIDTH-1:0] & mask;
  assign sm   = seed_q[MAX_WIDTH-1:0] & mask;

  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      pm_rev[i] = pm[MAX_WIDTH-1-i];
      sm_rev[i] = sm[MAX_WIDTH-1-i];
    end
  end

  // Reflected mode keeps the register low-aligned, normal mode top-aligned
  always_comb begin
    if (rin_q) begin
      poly_d = pm_rev >> shamt_d;
      seed_d = sm_rev >> shamt_d;
    end else begin
      poly_d = pm << shamt_d;
      seed_d = sm << shamt_d;
    end
    xmask_d = xor_q[MAX_WIDTH-1:0] & mask;
  end

  // Derived values follow the registers in the next cycle
  always_ff @(posedge clk_i) begin
    poly_q2 <= poly_d;
    seed_q2 <= seed_d;
    xmask_q <= xmask_d;
    shamt_q <= shamt_d;
  end

  // Reload sequence: settle derived values, then load the seed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rl1_q <= 1'b1;
      rl2_q <= 1'b0;
    end else begin
      rl1_q <= rl1_d;
      rl2_q <= rl1_q;
    end
  end

  assign ctrl_o.ref_in  = rin_q;
  assign ctrl_o.ref_out = rout_q;
  assign ctrl_o.hold    = rl1_q;
  assign ctrl_o.reload  = rl2_q;
  assign poly_o  = poly_q2;
  assign seed_o  = seed_q2;
  assign xmask_o = xmask_q;
  assign shamt_o = shamt_q;

  // A seed load always comes in the cycle after the hold
  a_reload_after_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rl2_q |-> $past(rl1_q))
    else $error("reload without preceding hold");

endmodule

// ===== design/pcrc_datapath.sv =====
// CRC datapath: input beat register, one byte of division per cycle unless
// stalled, finish, result register. Depends on pcrc_pkg, both interfaces.
module pcrc_datapath import pcrc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int unsigned SW = $clog2(MAX_WIDTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pcrc_in_if.sink              in_i,
  pcrc_out_if.source           out_o,
  input  ctrl_t                ctrl_i,
  input  logic [MAX_WIDTH-1:0] poly_i,
  input  logic [MAX_WIDTH-1:0] seed_i,
  input  logic [MAX_WIDTH-1:0] xmask_i,
  input  logic [SW-1:0]        shamt_i
);

  logic                 s1_valid_q;
  logic [OP_W-1:0]      s1_op_q;
  logic [BYTE_W-1:0]    s1_byte_q;
  logic                 s1_has_byte, s1_fin, s1_adv, out_free;
  logic [MAX_WIDTH-1:0] crc_q, crc_d;
  logic [MAX_WIDTH-1:0] absorbed, pre, pre_rev, turned, res;
  logic                 out_valid_q, out_valid_d;
  logic [CRC_OUT_W-1:0] out_crc_q;

  // Decode the buffered operation
  always_comb begin
    unique case (op_e'(s1_op_q))
      OP_ABSORB:        begin s1_has_byte = 1'b1; s1_fin = 1'b0; end
      OP_ABSORB_FINISH: begin s1_has_byte = 1'b1; s1_fin = 1'b1; end
      OP_FINISH:        begin s1_has_byte = 1'b0; s1_fin = 1'b1; end
      default:          begin s1_has_byte = 1'b0; s1_fin = 1'b0; end
    endcase
  end

  // Flow control: a beat leaves stage 1 unless its result cannot be stored
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && (!s1_fin || out_free);
  assign in_i.ready = (!s1_valid_q || s1_adv) && !ctrl_i.hold;

  // Input beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_op_q   <= in_i.operation;
      s1_byte_q <= in_i.data_byte;
    end
  end

  // Eight shift-XOR steps, one per message bit
  always_comb begin
    logic [MAX_WIDTH-1:0] r;
    logic                 fb;
    r = crc_q;
    for (int i = 0; i < BYTE_W; i++) begin
      if (ctrl_i.ref_in) begin
        fb = r[0] ^ s1_byte_q[i];
        r  = r >> 1;
      end else begin
        fb = r[MAX_WIDTH-1] ^ s1_byte_q[BYTE_W-1-i];
        r  = r << 1;
      end
      if (fb) begin
        r = r ^ poly_i;
      end
    end
    absorbed = r;
  end

  assign pre = s1_has_byte ? absorbed : crc_q;

  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      pre_rev[i] = pre[MAX_WIDTH-1-i];
    end
  end

  // Finish: reflect if the modes differ, align to bit 0, apply final XOR
  assign turned = (ctrl_i.ref_in ^ ctrl_i.ref_out) ? pre_rev : pre;
  assign res    = (ctrl_i.ref_out ? turned : (turned >> shamt_i)) ^ xmask_i;

  // CRC register update
  always_comb begin
    priority if (ctrl_i.reload) begin
      crc_d = seed_i;
    end else if (s1_adv && s1_fin) begin
      crc_d = seed_i;
    end else if (s1_adv && s1_has_byte) begin
      crc_d = absorbed;
    end else begin
      crc_d = crc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
  end

  // Result register
  always_comb begin
    if (s1_adv && s1_fin) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_fin) begin
      out_crc_q <= CRC_OUT_W'(res);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.crc_value = out_crc_q;

  // A stalled beat stays in stage 1
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q)
    else $error("stage 1 beat lost while stalled");

  // A finishing beat that leaves stage 1 shows up as a result
  a_fin_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_fin |=> out_o.valid)
    else $error("finish did not produce a result");

  // A full, untaken result register blocks a finishing beat
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready && s1_valid_q && s1_fin |-> !s1_adv)
    else $error("result overwritten before taken");

endmodule

// ===== design/parameterized_crc_engine_core.sv =====
// A finishing beat passes the input beat register, then the result register.
// Throughput: one beat per cycle unless input is held off or a finish waits
// on an untaken result; the byte update is one pass of eight shift-XOR steps
// between the input register and the CRC register. Reset loads the CRC-32
// configuration; input is held off after reset and after each register write.
// Depends on pcrc_pkg, pcrc_in_if, pcrc_out_if, pcrc_cfg_regs, pcrc_datapath.
module parameterized_crc_engine_core import pcrc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int unsigned SW = $clog2(MAX_WIDTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pcrc_in_if.sink               in_i,
  pcrc_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  ctrl_t                ctrl;
  logic [MAX_WIDTH-1:0] poly, seed, xmask;
  logic [SW-1:0]        shamt;

  // Configuration registers and derived constants
  pcrc_cfg_regs #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctrl_o  (ctrl),
    .poly_o  (poly),
    .seed_o  (seed),
    .xmask_o (xmask),
    .shamt_o (shamt)
  );

  // Byte pipeline
  pcrc_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .ctrl_i  (ctrl),
    .poly_i  (poly),
    .seed_i  (seed),
    .xmask_i (xmask),
    .shamt_i (shamt)
  );

endmodule
